// File: rtl/two_level_page_walk_core_defines.svh
// Assertion macros shared by the page walk RTL
`ifndef TWO_LEVEL_PAGE_WALK_CORE_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TLPW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tlpw_pkg.sv
// Types and constants for the two-level page walk core
`timescale 1ns / 1ps

package tlpw_pkg;

    localparam int ENTRIES_PER_LEVEL = 1024;
    localparam int DIR_IDX_W         = 10;
    localparam int PAGE_OFF_W        = 22;
    localparam int FLAGS_W           = 12;
    localparam int PRESENT_BIT       = 0;
    localparam int LARGE_BIT         = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] FUNC_DIR_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TAB_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

    typedef enum logic [1:0] {
        OP_DIR_WRITE,
        OP_TAB_WRITE,
        OP_TRANSLATE,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] virt_addr;
        logic [31:0] entry_word;
    } req_item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] phys_addr;
        logic [11:0] entry_flags;
        logic        write_error;
    } rsp_item_t;

    typedef struct packed {
        op_t                   op;
        logic [DIR_IDX_W-1:0]  dir_idx;
        logic [PAGE_OFF_W-1:0] page_off;
        logic [31:0]           word;
    } queue_entry_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// File: rtl/two_level_page_walk_core.sv
// A transaction passes from its queue slot to the directory read register and then to the
// result register; a small-page walk also passes through the table read register.
// Throughput: one transaction per cycle for writes and translations that resolve at the
// directory while the result register is free; a table read holds back the next one.
// Reset: a clearing pass writes zero to every entry of both memories;
// req_ready stays low until it ends.
`timescale 1ns / 1ps

module two_level_page_walk_core #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tlpw_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tlpw_pkg::rsp_item_t rsp
);

    logic                   q_valid;
    logic                   q_pop;
    tlpw_pkg::queue_entry_t q_entry;
    tlpw_pkg::back_status_t status;

    tlpw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .status    (status),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    tlpw_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: rtl/tlpw_front.sv
// Front end: accept, decode and queue page walk transactions
`timescale 1ns / 1ps
`include "two_level_page_walk_core_defines.svh"

module tlpw_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tlpw_pkg::req_item_t    req,
    input  tlpw_pkg::back_status_t status,
    output logic                   q_valid,
    output tlpw_pkg::queue_entry_t q_entry,
    input  logic                   q_pop
);

    tlpw_pkg::queue_entry_t                 slots_reg [tlpw_pkg::QUEUE_DEPTH];
    tlpw_pkg::queue_entry_t                 entry_next;
    logic [tlpw_pkg::QPTR_W-1:0]            wr_ptr_reg;
    logic [tlpw_pkg::QPTR_W-1:0]            wr_ptr_next;
    logic [tlpw_pkg::QPTR_W-1:0]            rd_ptr_reg;
    logic [tlpw_pkg::QPTR_W-1:0]            rd_ptr_next;
    logic [tlpw_pkg::QCNT_W-1:0]            count_reg;
    logic [tlpw_pkg::QCNT_W-1:0]            count_next;
    logic                                   push;

    always_comb
    begin
        entry_next.dir_idx  = req.virt_addr[31:22];
        entry_next.page_off = req.virt_addr[21:0];
        entry_next.word     = req.entry_word;
        case (req.func)
            tlpw_pkg::FUNC_DIR_WRITE: entry_next.op = tlpw_pkg::OP_DIR_WRITE;
            tlpw_pkg::FUNC_TAB_WRITE: entry_next.op = tlpw_pkg::OP_TAB_WRITE;
            tlpw_pkg::FUNC_TRANSLATE: entry_next.op = tlpw_pkg::OP_TRANSLATE;
            default:                  entry_next.op = tlpw_pkg::OP_NOP;
        endcase
    end

    assign req_ready = (count_reg != tlpw_pkg::QCNT_W'(tlpw_pkg::QUEUE_DEPTH))
                       && !status.clearing;
    assign push      = req_valid && req_ready;
    assign q_valid   = (count_reg != '0);
    assign q_entry   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= entry_next;
        end
    end

    `TLPW_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= tlpw_pkg::QCNT_W'(tlpw_pkg::QUEUE_DEPTH), "queue count overflow")
    `TLPW_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, count_reg != '0, "pop from empty queue")
    `TLPW_ASSERT_IMPLIES(a_no_push_clear, clk, rst_n, status.clearing, !push, "transaction accepted during clear")

endmodule

// File: rtl/tlpw_back.sv
// Back end: directory and table memories, walk sequencer, result register
`timescale 1ns / 1ps
`include "two_level_page_walk_core_defines.svh"

module tlpw_back #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  tlpw_pkg::queue_entry_t q_entry,
    output logic                   q_pop,
    output tlpw_pkg::back_status_t status,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output tlpw_pkg::rsp_item_t    rsp
);

    localparam int TABLE_DEPTH = TABLE_SLOTS * tlpw_pkg::ENTRIES_PER_LEVEL;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int DIR_AW      = tlpw_pkg::DIR_IDX_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_TAB
    } state_t;

    logic [31:0] dir_mem [tlpw_pkg::ENTRIES_PER_LEVEL];
    logic [31:0] tab_mem [TABLE_DEPTH];

    state_t                 state_reg;
    state_t                 state_next;
    logic [TAB_AW-1:0]      clr_cnt_reg;
    logic [TAB_AW-1:0]      clr_cnt_next;
    tlpw_pkg::queue_entry_t cur_reg;
    tlpw_pkg::queue_entry_t cur_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    tlpw_pkg::rsp_item_t    rsp_reg;
    tlpw_pkg::rsp_item_t    rsp_next;

    logic [31:0]       dir_rdata_reg;
    logic [31:0]       tab_rdata_reg;
    logic              dir_we;
    logic              dir_re;
    logic [DIR_AW-1:0] dir_waddr;
    logic [31:0]       dir_wdata;
    logic              tab_we;
    logic              tab_re;
    logic [TAB_AW-1:0] tab_waddr;
    logic [31:0]       tab_wdata;
    logic [TAB_AW-1:0] tab_addr;

    logic de_present;
    logic de_large;
    logic slot_in_range;
    logic small_ok;
    logic small_walk;
    logic out_free;
    logic can_pop;
    logic load_rsp;

    assign de_present    = dir_rdata_reg[tlpw_pkg::PRESENT_BIT];
    assign de_large      = dir_rdata_reg[tlpw_pkg::LARGE_BIT];
    assign slot_in_range = ({12'd0, dir_rdata_reg[31:12]} < 32'(TABLE_SLOTS));
    assign small_ok      = de_present && !de_large && slot_in_range;
    assign small_walk    = (cur_reg.op == tlpw_pkg::OP_TRANSLATE) && small_ok;
    assign tab_addr      = TAB_AW'({dir_rdata_reg[31:12], cur_reg.page_off[21:12]});
    assign out_free      = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        can_pop        = 1'b0;
        load_rsp       = 1'b0;
        dir_we         = 1'b0;
        dir_re         = 1'b0;
        dir_waddr      = q_entry.dir_idx;
        dir_wdata      = q_entry.word;
        tab_we         = 1'b0;
        tab_re         = 1'b0;
        tab_waddr      = tab_addr;
        tab_wdata      = cur_reg.word;

        case (state_reg)
            ST_CLEAR:
            begin
                dir_we       = 1'b1;
                dir_waddr    = clr_cnt_reg[DIR_AW-1:0];
                dir_wdata    = '0;
                tab_we       = 1'b1;
                tab_waddr    = clr_cnt_reg;
                tab_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == TAB_AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                can_pop = 1'b1;
            end
            ST_DIR:
            begin
                if (small_walk)
                begin
                    tab_re     = 1'b1;
                    state_next = ST_TAB;
                end
                else if (out_free)
                begin
                    load_rsp   = 1'b1;
                    can_pop    = 1'b1;
                    state_next = ST_IDLE;
                    rsp_next   = '0;
                    case (cur_reg.op)
                        tlpw_pkg::OP_TAB_WRITE:
                        begin
                            tab_we               = small_ok;
                            rsp_next.write_error = !small_ok;
                        end
                        tlpw_pkg::OP_TRANSLATE:
                        begin
                            if (de_present && de_large)
                            begin
                                rsp_next.hit         = 1'b1;
                                rsp_next.phys_addr   = {dir_rdata_reg[31:22],
                                                        cur_reg.page_off};
                                rsp_next.entry_flags = dir_rdata_reg[11:0];
                            end
                        end
                        default:
                        begin
                            rsp_next = '0;
                        end
                    endcase
                end
            end
            ST_TAB:
            begin
                if (out_free)
                begin
                    load_rsp   = 1'b1;
                    can_pop    = 1'b1;
                    state_next = ST_IDLE;
                    rsp_next   = '0;
                    if (tab_rdata_reg[tlpw_pkg::PRESENT_BIT])
                    begin
                        rsp_next.hit         = 1'b1;
                        rsp_next.phys_addr   = {tab_rdata_reg[31:12], cur_reg.page_off[11:0]};
                        rsp_next.entry_flags = tab_rdata_reg[11:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end

        q_pop = can_pop && q_valid;
        if (q_pop)
        begin
            state_next = ST_DIR;
            cur_next   = q_entry;
            dir_re     = 1'b1;
            dir_we     = (q_entry.op == tlpw_pkg::OP_DIR_WRITE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_reg       <= cur_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re)
        begin
            dir_rdata_reg <= dir_mem[q_entry.dir_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re)
        begin
            tab_rdata_reg <= tab_mem[tab_addr];
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

    `TLPW_ASSERT_IMPLIES(a_no_pop_clear, clk, rst_n, state_reg == ST_CLEAR, !q_pop, "queue popped during clear")
    `TLPW_ASSERT_IMPLIES(a_load_free, clk, rst_n, load_rsp, out_free, "result overwrites pending transaction")
    `TLPW_ASSERT_NEXT(a_walk_tab, clk, rst_n, tab_re, state_reg == ST_TAB, "table read without table stage")
    `TLPW_ASSERT_IMPLIES(a_tab_we_ok, clk, rst_n, tab_we && (state_reg != ST_CLEAR), (cur_reg.op == tlpw_pkg::OP_TAB_WRITE) && small_ok, "table write without valid directory entry")

endmodule

// File: bench/tb_two_level_page_walk_core.sv
// Self-checking testbench for the two-level page walk core with large-page support
`timescale 1ns / 1ps

module tb_two_level_page_walk_core;

    localparam int TABLE_SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int POOL_SIZE = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    tlpw_pkg::req_item_t req = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    tlpw_pkg::rsp_item_t rsp;

    bit [31:0] dir_mem [tlpw_pkg::ENTRIES_PER_LEVEL];
    bit [31:0] tab_mem [TABLE_SLOTS * tlpw_pkg::ENTRIES_PER_LEVEL];

    tlpw_pkg::req_item_t req_backlog_q [$];
    tlpw_pkg::rsp_item_t walk_results_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned dir_pool [POOL_SIZE];
    int unsigned tab_pool [POOL_SIZE];

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned hit_count = 0;
    int unsigned refusal_count = 0;

    two_level_page_walk_core #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic tlpw_pkg::rsp_item_t predict_walk(input tlpw_pkg::req_item_t t);
        tlpw_pkg::rsp_item_t r;
        logic [31:0]         de;
        logic [31:0]         te;
        int unsigned         slot;
        int unsigned         pos;
        bit                  tab_ok;
        r = '0;
        de = dir_mem[t.virt_addr[31:22]];
        slot = {12'd0, de[31:12]};
        tab_ok = de[tlpw_pkg::PRESENT_BIT] && !de[tlpw_pkg::LARGE_BIT]
                 && (slot < TABLE_SLOTS);
        pos = slot * tlpw_pkg::ENTRIES_PER_LEVEL + {22'd0, t.virt_addr[21:12]};
        case (tlpw_pkg::op_t'(t.func))
            tlpw_pkg::OP_DIR_WRITE: dir_mem[t.virt_addr[31:22]] = t.entry_word;
            tlpw_pkg::OP_TAB_WRITE:
            begin
                if (tab_ok)
                    tab_mem[pos] = t.entry_word;
                else
                    r.write_error = 1'b1;
            end
            tlpw_pkg::OP_TRANSLATE:
            begin
                if (de[tlpw_pkg::PRESENT_BIT] && de[tlpw_pkg::LARGE_BIT])
                begin
                    r.hit = 1'b1;
                    r.phys_addr = {de[31:22], t.virt_addr[21:0]};
                    r.entry_flags = de[11:0];
                end
                else if (tab_ok)
                begin
                    te = tab_mem[pos];
                    if (te[tlpw_pkg::PRESENT_BIT])
                    begin
                        r.hit = 1'b1;
                        r.phys_addr = {te[31:12], t.virt_addr[11:0]};
                        r.entry_flags = te[11:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_item(input tlpw_pkg::op_t f, input logic [31:0] va,
                              input logic [31:0] w);
        tlpw_pkg::req_item_t t;
        t.func = f;
        t.virt_addr = va;
        t.entry_word = w;
        req_backlog_q.push_back(t);
    endtask

    task automatic refresh_pools();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            dir_pool[i] = $urandom_range(tlpw_pkg::ENTRIES_PER_LEVEL - 1);
            tab_pool[i] = $urandom_range(tlpw_pkg::ENTRIES_PER_LEVEL - 1);
        end
        if ($urandom_range(1))
        begin
            dir_pool[0] = 0;
            dir_pool[POOL_SIZE - 1] = tlpw_pkg::ENTRIES_PER_LEVEL - 1;
            tab_pool[0] = 0;
            tab_pool[POOL_SIZE - 1] = tlpw_pkg::ENTRIES_PER_LEVEL - 1;
        end
    endtask

    task automatic queue_random_item();
        int unsigned         pick;
        int unsigned         kind;
        logic [31:0]         va;
        logic [31:0]         w;
        tlpw_pkg::req_item_t t;
        pick = $urandom_range(99);
        kind = $urandom_range(99);
        va = {dir_pool[$urandom_range(POOL_SIZE - 1)][9:0],
              tab_pool[$urandom_range(POOL_SIZE - 1)][9:0],
              12'($urandom())};
        w = $urandom();
        if (pick < 15)
        begin
            if (kind < 60)
            begin
                w[31:12] = 20'($urandom_range(TABLE_SLOTS - 1));
                w[tlpw_pkg::PRESENT_BIT] = 1'b1;
                w[tlpw_pkg::LARGE_BIT] = 1'b0;
            end
            else if (kind < 75)
            begin
                w[tlpw_pkg::PRESENT_BIT] = 1'b1;
                w[tlpw_pkg::LARGE_BIT] = 1'b1;
            end
            else if (kind < 85)
                w[tlpw_pkg::PRESENT_BIT] = 1'b0;
            else if (kind < 95)
            begin
                w[31:12] = 20'($urandom_range(20'hFFFFF, TABLE_SLOTS));
                w[tlpw_pkg::PRESENT_BIT] = 1'b1;
                w[tlpw_pkg::LARGE_BIT] = 1'b0;
            end
            queue_item(tlpw_pkg::OP_DIR_WRITE, va, w);
        end
        else if (pick < 45)
        begin
            if (kind < 80)
                w[tlpw_pkg::PRESENT_BIT] = 1'b1;
            queue_item(tlpw_pkg::OP_TAB_WRITE, va, w);
        end
        else if (pick < 90)
            queue_item(tlpw_pkg::OP_TRANSLATE, va, w);
        else if (pick < 95)
        begin
            t.func = 2'($urandom_range(3));
            t.virt_addr = $urandom();
            t.entry_word = w;
            req_backlog_q.push_back(t);
        end
        else
            queue_item(tlpw_pkg::OP_NOP, $urandom(), w);
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        refresh_pools();
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            queue_random_item();
        while (req_backlog_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit take;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            take = !req_valid;
            if (req_valid && req_ready)
            begin
                walk_results_q.push_back(predict_walk(req));
                void'(req_backlog_q.pop_front());
                sent_count++;
                take = 1'b1;
            end
            if (take)
            begin
                if (req_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= req_backlog_q[0];
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tlpw_pkg::rsp_item_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (walk_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: hit=%0b phys=%h flags=%h err=%0b",
                                 rsp.hit, rsp.phys_addr, rsp.entry_flags, rsp.write_error);
                end
                else
                begin
                    want = walk_results_q.pop_front();
                    checked_count++;
                    hit_count += {31'd0, want.hit};
                    refusal_count += {31'd0, want.write_error};
                    if (rsp.hit !== want.hit || rsp.phys_addr !== want.phys_addr
                        || rsp.entry_flags !== want.entry_flags
                        || rsp.write_error !== want.write_error)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch #%0d: exp hit=%0b phys=%h flags=%h err=%0b, %s",
                                     checked_count, want.hit, want.phys_addr,
                                     want.entry_flags, want.write_error,
                                     $sformatf("got hit=%0b phys=%h flags=%h err=%0b",
                                               rsp.hit, rsp.phys_addr, rsp.entry_flags,
                                               rsp.write_error));
                    end
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[two_level_page_walk_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_item(tlpw_pkg::OP_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_item(tlpw_pkg::OP_TAB_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_item(tlpw_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(tlpw_pkg::OP_DIR_WRITE, 32'h0000_0000, 32'h0000_3067);
        queue_item(tlpw_pkg::OP_TAB_WRITE, {10'd0, 10'd5, 12'h000}, 32'hFFFF_FFFF);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd0, 10'd5, 12'hFFF}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd0, 10'd6, 12'h123}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_DIR_WRITE, 32'hFFC0_0000, 32'hFFC0_0081);
        queue_item(tlpw_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_TAB_WRITE, 32'hFFFF_F000, 32'h0000_1001);
        queue_item(tlpw_pkg::OP_DIR_WRITE, {10'd2, 22'd0}, 32'h0001_0001);
        queue_item(tlpw_pkg::OP_TAB_WRITE, {10'd2, 22'd0}, 32'h0000_1001);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd2, 22'd0}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_DIR_WRITE, {10'd3, 22'd0}, 32'h0000_F001);
        queue_item(tlpw_pkg::OP_TAB_WRITE, {10'd3, 10'd1023, 12'h000}, 32'h1234_5001);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd3, 10'd1023, 12'hABC}, 32'hFFFF_FFFF);
        queue_item(tlpw_pkg::OP_DIR_WRITE, {10'd4, 22'd0}, 32'h0040_0080);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd4, 22'h3FFFFF}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_TAB_WRITE, {10'd0, 10'd5, 12'h000}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd0, 10'd5, 12'h000}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_DIR_WRITE, {10'd5, 22'd0}, 32'hFFFF_FFFF);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd5, 22'h2AAAAA}, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_DIR_WRITE, 32'h0000_0000, 32'h0000_0000);
        queue_item(tlpw_pkg::OP_TRANSLATE, {10'd0, 10'd5, 12'hFFF}, 32'h0000_0000);
        while (req_backlog_q.size() != 0)
            @(posedge clk);

        run_random_phase(0, 0);
        run_random_phase(57, 0);

        while (walk_results_q.size() != 0)
            @(posedge clk);

        run_random_phase(0, 57);
        run_random_phase(30, 30);

        while (walk_results_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("checked %0d of %0d transactions over four idle/stall phases",
                 checked_count, sent_count);
        $display("%0d translate hits, %0d refused table writes, %0d failures",
                 hit_count, refusal_count, fail_count);
        if (fail_count == 0 && walk_results_q.size() == 0)
            $display("[two_level_page_walk_core] OK");
        else
            $display("[two_level_page_walk_core] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tlpw_pkg.sv
rtl/tlpw_front.sv
rtl/tlpw_back.sv
rtl/two_level_page_walk_core.sv
bench/tb_two_level_page_walk_core.sv
